// ----- sv/paspsw_pkg.sv -----
// Package for the staged power switch: sizes, widths, register codes,
// reset values and the sequencer state type.
// Has no dependencies; every other file imports it.
`default_nettype none

package paspsw_pkg;

   // Ring sizes. The peak ring depth must be a power of two.
   localparam int SAMPLE_DEPTH = 16;
   localparam int PEAK_DEPTH   = 8;
   localparam int SAMPLE_AW    = $clog2(SAMPLE_DEPTH);
   localparam int PEAK_AW      = $clog2(PEAK_DEPTH);
   localparam int SCAN_MAX     = (SAMPLE_DEPTH > PEAK_DEPTH) ? SAMPLE_DEPTH : PEAK_DEPTH;
   localparam int CNT_W        = $clog2(SCAN_MAX + 1);

   // Field widths.
   localparam int ADC_W      = 10;
   localparam int VPC_W      = 24;
   localparam int VOLT_W     = 16;
   localparam int IVAL_W     = 16;
   localparam int GROUPS     = 3;
   localparam int PROD_W     = ADC_W + VPC_W;
   localparam int FRAC_SHIFT = 16;
   localparam int SUM_W      = VOLT_W + PEAK_AW;

   // Configuration port.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_VOLTS_PER_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ON_THRESHOLD    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OFF_THRESHOLD   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BOOT_INTERVAL   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_AUTO_SWITCH     = 3'd4;

   localparam logic [VPC_W-1:0]  RST_VOLTS_PER_COUNT = 24'd82000;
   localparam logic [VOLT_W-1:0] RST_ON_THRESHOLD    = 16'd1792;
   localparam logic [VOLT_W-1:0] RST_OFF_THRESHOLD   = 16'd1664;
   localparam logic [IVAL_W-1:0] RST_BOOT_INTERVAL   = 16'd10;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_WR_SAMPLE,
      ST_SCAN_SAMPLE,
      ST_WR_PEAK,
      ST_SCAN_PEAK,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

// ----- sv/peak_average_staged_power_switch.sv -----
// Staged power switch driven by a windowed peak moving average.
// Depends on paspsw_pkg.
//
// Each request carries one raw ADC sample and produces exactly one response.
// A request runs from acceptance to the response register through the
// scale and write steps and the two scans that read the sample ring and
// the peak ring one entry per cycle through the single read port of each
// ring memory. The next request can be taken in the cycle after the
// response is loaded. One request is in work at a time; req_stall is high
// from acceptance until the response is loaded, and a finished response
// waits in its own register so the next request can be taken while it is
// still stalled. Both rings read as zero after reset through per-entry
// valid bits, so no clearing pass is needed. Configuration writes are
// always taken (csr_ready is tied high) and must only be issued while no
// request is in flight.
`default_nettype none

module peak_average_staged_power_switch (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request channel
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [paspsw_pkg::ADC_W-1:0]       req_adc_sample,
   // response channel
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [paspsw_pkg::VOLT_W-1:0]           rsp_avg_peak_voltage,
   output logic                                    rsp_target_on,
   output logic                                    rsp_group_one_on,
   output logic                                    rsp_group_two_on,
   output logic                                    rsp_group_three_on,
   // configuration channel
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [paspsw_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [paspsw_pkg::CSR_DATA_W-1:0]  csr_data
);
   import paspsw_pkg::*;

   // Configuration registers.
   logic [VPC_W-1:0]  vpc_ff;
   logic [VOLT_W-1:0] on_thr_ff;
   logic [VOLT_W-1:0] off_thr_ff;
   logic [IVAL_W-1:0] interval_ff;
   logic              auto_ff;

   // Sequencer and control state.
   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff;
   logic [SAMPLE_AW-1:0] s_pos_ff;
   logic [PEAK_AW-1:0]   p_pos_ff;
   logic              target_ff, target_in;
   logic [IVAL_W-1:0] tick_ff, tick_in;
   logic [GROUPS-1:0] group_ff, group_in;
   logic              rsp_valid_ff;
   logic [SAMPLE_DEPTH-1:0] s_vld_ff;
   logic [PEAK_DEPTH-1:0]   p_vld_ff;

   // Payload registers.
   logic [ADC_W-1:0]  adc_ff;
   logic [VOLT_W-1:0] scaled_ff, scaled_in;
   logic [VOLT_W-1:0] peak_ff;
   logic [SUM_W-1:0]  sum_ff;
   logic [VOLT_W-1:0] rsp_avg_ff;

   // Ring memories with registered read data.
   logic [VOLT_W-1:0] s_mem [SAMPLE_DEPTH];
   logic [VOLT_W-1:0] p_mem [PEAK_DEPTH];
   logic [VOLT_W-1:0] s_rd_data_ff;
   logic [VOLT_W-1:0] p_rd_data_ff;
   logic              s_rd_ok_ff;
   logic              p_rd_ok_ff;

   // Decoded controls.
   logic accept;
   logic slot_free;
   logic s_we, s_rd_en, s_consume;
   logic p_we, p_rd_en, p_consume;
   logic cnt_clr, cnt_inc;
   logic load_rsp;

   logic [PROD_W-1:0]   product;
   logic [VOLT_W-1:0]   s_rd_val, p_rd_val;
   logic [VOLT_W-1:0]   avg;
   logic [IVAL_W:0]     tick_next;

   function automatic logic [GROUPS-1:0] stage_groups(input logic [GROUPS-1:0] cur,
                                                      input logic             tgt);
      logic [GROUPS-1:0] res;
      logic              done;
      res  = cur;
      done = 1'b0;
      for (int g = 0; g < GROUPS; g++) begin
         if (!done && (cur[g] != tgt)) begin
            res[g] = tgt;
            done   = 1'b1;
         end
      end
      return res;
   endfunction

   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   // Sample scaling: truncate the Q10.24 product to Q8.8 and saturate.
   assign product = {{VPC_W{1'b0}}, adc_ff} * {{ADC_W{1'b0}}, vpc_ff};
   always_comb begin
      if (|product[PROD_W-1:FRAC_SHIFT+VOLT_W]) begin
         scaled_in = {VOLT_W{1'b1}};
      end else begin
         scaled_in = product[FRAC_SHIFT+VOLT_W-1:FRAC_SHIFT];
      end
   end

   // Entries never written since reset read as zero.
   assign s_rd_val = s_rd_ok_ff ? s_rd_data_ff : '0;
   assign p_rd_val = p_rd_ok_ff ? p_rd_data_ff : '0;

   assign avg = sum_ff[SUM_W-1:PEAK_AW];

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SCALE;
         end
         ST_SCALE:     state_in = ST_WR_SAMPLE;
         ST_WR_SAMPLE: state_in = ST_SCAN_SAMPLE;
         ST_SCAN_SAMPLE: begin
            if (cnt_ff == CNT_W'(SAMPLE_DEPTH)) state_in = ST_WR_PEAK;
         end
         ST_WR_PEAK:   state_in = ST_SCAN_PEAK;
         ST_SCAN_PEAK: begin
            if (cnt_ff == CNT_W'(PEAK_DEPTH)) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State outputs.
   always_comb begin
      req_stall = 1'b1;
      s_we      = 1'b0;
      s_rd_en   = 1'b0;
      s_consume = 1'b0;
      p_we      = 1'b0;
      p_rd_en   = 1'b0;
      p_consume = 1'b0;
      cnt_clr   = 1'b0;
      cnt_inc   = 1'b0;
      load_rsp  = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_stall = 1'b0;
         ST_SCALE: begin
         end
         ST_WR_SAMPLE: begin
            s_we    = 1'b1;
            cnt_clr = 1'b1;
         end
         ST_SCAN_SAMPLE: begin
            s_rd_en   = (cnt_ff != CNT_W'(SAMPLE_DEPTH));
            s_consume = (cnt_ff != '0);
            cnt_inc   = 1'b1;
         end
         ST_WR_PEAK: begin
            p_we    = 1'b1;
            cnt_clr = 1'b1;
         end
         ST_SCAN_PEAK: begin
            p_rd_en   = (cnt_ff != CNT_W'(PEAK_DEPTH));
            p_consume = (cnt_ff != '0);
            cnt_inc   = 1'b1;
         end
         ST_DONE:  load_rsp = slot_free;
         default: begin
         end
      endcase
   end

   // Hysteresis and group staging, applied when the response is loaded.
   always_comb begin
      target_in = target_ff;
      tick_in   = tick_ff;
      group_in  = group_ff;
      tick_next = {1'b0, tick_ff} + 1'b1;
      if (auto_ff) begin
         if (avg > on_thr_ff) begin
            target_in = 1'b1;
         end else if (avg < off_thr_ff) begin
            target_in = 1'b0;
         end
         // An interval of zero acts on every tick, like an interval of one.
         if (tick_next < {1'b0, interval_ff}) begin
            tick_in = tick_next[IVAL_W-1:0];
         end else begin
            tick_in  = '0;
            group_in = stage_groups(group_ff, target_in);
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         s_pos_ff     <= '0;
         p_pos_ff     <= '0;
         target_ff    <= 1'b0;
         tick_ff      <= '0;
         group_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         s_vld_ff     <= '0;
         p_vld_ff     <= '0;
         vpc_ff       <= RST_VOLTS_PER_COUNT;
         on_thr_ff    <= RST_ON_THRESHOLD;
         off_thr_ff   <= RST_OFF_THRESHOLD;
         interval_ff  <= RST_BOOT_INTERVAL;
         auto_ff      <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cnt_clr) begin
            cnt_ff <= '0;
         end else if (cnt_inc) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
         if (s_we) begin
            s_vld_ff[s_pos_ff] <= 1'b1;
            if (s_pos_ff == SAMPLE_AW'(SAMPLE_DEPTH - 1)) begin
               s_pos_ff <= '0;
            end else begin
               s_pos_ff <= s_pos_ff + 1'b1;
            end
         end
         if (p_we) begin
            p_vld_ff[p_pos_ff] <= 1'b1;
            if (p_pos_ff == PEAK_AW'(PEAK_DEPTH - 1)) begin
               p_pos_ff <= '0;
            end else begin
               p_pos_ff <= p_pos_ff + 1'b1;
            end
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
            target_ff    <= target_in;
            tick_ff      <= tick_in;
            group_ff     <= group_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_VOLTS_PER_COUNT: vpc_ff      <= csr_data[VPC_W-1:0];
               CSR_ON_THRESHOLD:    on_thr_ff   <= csr_data[VOLT_W-1:0];
               CSR_OFF_THRESHOLD:   off_thr_ff  <= csr_data[VOLT_W-1:0];
               CSR_BOOT_INTERVAL:   interval_ff <= csr_data[IVAL_W-1:0];
               CSR_AUTO_SWITCH:     auto_ff     <= csr_data[0];
               default: begin
               end
            endcase
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) adc_ff <= req_adc_sample;
      if (state_ff == ST_SCALE) scaled_ff <= scaled_in;
      if (s_we) begin
         peak_ff <= '0;
      end else if (s_consume && (s_rd_val > peak_ff)) begin
         peak_ff <= s_rd_val;
      end
      if (p_we) begin
         sum_ff <= '0;
      end else if (p_consume) begin
         sum_ff <= sum_ff + SUM_W'(p_rd_val);
      end
      if (load_rsp) rsp_avg_ff <= avg;
   end

   // Sample ring memory.
   always_ff @(posedge clock) begin
      if (s_we) s_mem[s_pos_ff] <= scaled_ff;
      if (s_rd_en) begin
         s_rd_data_ff <= s_mem[cnt_ff[SAMPLE_AW-1:0]];
         s_rd_ok_ff   <= s_vld_ff[cnt_ff[SAMPLE_AW-1:0]];
      end
   end

   // Peak ring memory.
   always_ff @(posedge clock) begin
      if (p_we) p_mem[p_pos_ff] <= peak_ff;
      if (p_rd_en) begin
         p_rd_data_ff <= p_mem[cnt_ff[PEAK_AW-1:0]];
         p_rd_ok_ff   <= p_vld_ff[cnt_ff[PEAK_AW-1:0]];
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_avg_peak_voltage = rsp_avg_ff;
   assign rsp_target_on        = target_ff;
   assign rsp_group_one_on     = group_ff[0];
   assign rsp_group_two_on     = group_ff[1];
   assign rsp_group_three_on   = group_ff[2];

endmodule

`default_nettype wire

// ----- sv/paspsw_checker.sv -----
// Port-level checks for the staged power switch, bound to the top level.
// Depends on paspsw_pkg and peak_average_staged_power_switch.
`default_nettype none

module paspsw_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_valid,
   input wire logic                               req_stall,
   input wire logic [paspsw_pkg::ADC_W-1:0]       req_adc_sample,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_stall,
   input wire logic [paspsw_pkg::VOLT_W-1:0]      rsp_avg_peak_voltage,
   input wire logic                               rsp_target_on,
   input wire logic                               rsp_group_one_on,
   input wire logic                               rsp_group_two_on,
   input wire logic                               rsp_group_three_on,
   input wire logic                               csr_valid,
   input wire logic                               csr_ready,
   input wire logic [paspsw_pkg::CSR_IDX_W-1:0]   csr_index,
   input wire logic [paspsw_pkg::CSR_DATA_W-1:0]  csr_data
);
   import paspsw_pkg::*;

   logic [GROUPS-1:0] groups;
   assign groups = {rsp_group_three_on, rsp_group_two_on, rsp_group_one_on};

   // One request is worked on at a time.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while the previous one is in work");

   // A stalled response holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_avg_peak_voltage)
                                    && $stable(groups) && $stable(rsp_target_on)))
      else $error("stalled response changed");

   // Only one power group switches per step.
   a_one_group_step: assert property (@(posedge clock) disable iff (reset)
      $countones(groups ^ $past(groups)) <= 1)
      else $error("more than one power group switched at once");

   // Group enables only change together with a new response.
   a_groups_with_rsp: assert property (@(posedge clock) disable iff (reset)
      (groups != $past(groups)) |-> rsp_valid)
      else $error("power groups changed without a response");

endmodule

bind peak_average_staged_power_switch paspsw_checker u_paspsw_checker (.*);

`default_nettype wire
